// File: hdl/skpd_pkg.sv
// ----------------------------------------------------------------------------
// skpd_pkg
// Shared constants and register codes of the soft knee peak detector.
// ----------------------------------------------------------------------------
package skpd_pkg;

  // default sample and coefficient formats
  localparam int unsigned SAMPLE_BITS_DEF    = 18;
  localparam int unsigned COEF_FRAC_BITS_DEF = 16;

  // sign bit plus two integer bits in front of the sample fraction
  localparam int unsigned SAMPLE_INT_BITS = 3;

  // knee scale word, unsigned Q8.12
  localparam int unsigned KNEE_SCALE_BITS = 20;
  localparam int unsigned KNEE_FRAC_BITS  = 12;

  // decay coefficient after reset, Q1.16 code
  localparam int unsigned DECAY_COEF_RST = 62180;

  localparam int unsigned CFG_IDX_BITS = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_POLARITY      = 3'd0,
    REG_THRESHOLD     = 3'd1,
    REG_TRANS_WIDTH   = 3'd2,
    REG_KNEE_SCALE    = 3'd3,
    REG_CHARGE_COEF   = 3'd4,
    REG_DECAY_COEF    = 3'd5,
    REG_DECAY_INSTANT = 3'd6
  } cfg_reg_t;

endpackage

// File: hdl/skpd_mul.sv
// ----------------------------------------------------------------------------
// skpd_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module skpd_mul import skpd_pkg::*; #(
  parameter int unsigned AW = SAMPLE_BITS_DEF + 1,
  parameter int unsigned BW = COEF_FRAC_BITS_DEF + 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] prod
);

  logic [AW+BW-1:0] prod_r;

  // hold the product until the next issued operation
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= (AW+BW)'(a) * (AW+BW)'(b);
    end
  end

  assign prod = prod_r;

endmodule

// File: hdl/skpd_sqrt.sv
// ----------------------------------------------------------------------------
// skpd_sqrt
// Bit-serial restoring square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module skpd_sqrt import skpd_pkg::*; #(
  parameter int unsigned W = SAMPLE_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [2*W-1:0] radicand,
  output logic [W-1:0]   root,
  output logic           done
);

  localparam int unsigned CW = $clog2(W);

  logic           busy_r;
  logic           done_r;
  logic [CW-1:0]  cnt_r;
  logic [2*W-1:0] rad_r;
  logic [W:0]     rem_r;
  logic [W-1:0]   root_r;

  logic [W+2:0]   rem_t;
  logic [W+2:0]   trial;
  logic           ge;
  logic [W:0]     rem_nxt;
  logic [W-1:0]   root_nxt;

  always_comb begin
    rem_t    = {rem_r, rad_r[2*W-1 -: 2]};
    trial    = {1'b0, root_r, 2'b01};
    ge       = (rem_t >= trial);
    rem_nxt  = ge ? (W+1)'(rem_t - trial) : (W+1)'(rem_t);
    root_nxt = {root_r[W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // shift two radicand bits in per step
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= rad_r << 2;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign root = root_r;
  assign done = done_r;

endmodule

// File: hdl/soft_knee_peak_detector.sv
// ----------------------------------------------------------------------------
// soft_knee_peak_detector
// Steps: a real word on a hard knee or outside the knee runs knee, filter and
//   write-back; inside the soft knee it adds the scaled square, its sum and the
//   clip; a complex word first forms its magnitude with the bit-serial square root.
// Throughput: one word at a time; in_ready is high only in the idle state.
// Reset (synchronous, rst_n low): held level 0, registers at their defaults.
// ----------------------------------------------------------------------------
module soft_knee_peak_detector import skpd_pkg::*; #(
  parameter int unsigned SAMPLE_BITS    = SAMPLE_BITS_DEF,
  parameter int unsigned COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
  localparam int unsigned CFG_W =
    (SAMPLE_BITS > KNEE_SCALE_BITS) ?
      ((SAMPLE_BITS > COEF_FRAC_BITS + 1) ? SAMPLE_BITS : COEF_FRAC_BITS + 1) :
      ((KNEE_SCALE_BITS > COEF_FRAC_BITS + 1) ? KNEE_SCALE_BITS : COEF_FRAC_BITS + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // sample input
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_re,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_im,
  input  logic                          in_is_complex,
  // result output
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_level,
  output logic                          out_config_error,
  // register writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [CFG_W-1:0]              cfg_data
);

  localparam int unsigned N    = SAMPLE_BITS;
  localparam int unsigned CF   = COEF_FRAC_BITS;
  localparam int unsigned AW   = N + 1;            // multiplier operand a
  localparam int unsigned BW   = CFG_W;            // multiplier operand b
  localparam int unsigned PRW  = AW + BW;          // product
  localparam int unsigned H    = N - 1;            // split point of the squared distance
  localparam int unsigned D2W  = 2 * N - 2;        // squared knee distance
  localparam int unsigned PW   = D2W + KNEE_SCALE_BITS;
  localparam int unsigned KSH  = N - SAMPLE_INT_BITS + KNEE_FRAC_BITS;
  localparam int unsigned QW   = PW - KSH + 1;
  localparam int unsigned RW   = PRW - CF + 1;

  localparam logic signed [N-1:0]   SMAX   = {1'b0, {(N-1){1'b1}}};
  localparam logic signed [N-1:0]   SMIN   = {1'b1, {(N-1){1'b0}}};
  localparam logic        [N-1:0]   SMAX_U = {1'b0, {(N-1){1'b1}}};
  localparam logic signed [N+1:0]   SMAX_X = (N+2)'(SMAX);
  localparam logic signed [N+1:0]   SMIN_X = (N+2)'(SMIN);
  localparam logic        [CF:0]    COEF_ONE = {1'b1, {CF{1'b0}}};
  localparam logic        [CF:0]    DECAY_RST = (CF+1)'(DECAY_COEF_RST);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAG_A,
    ST_MAG_B,
    ST_MAG_C,
    ST_SQRT,
    ST_KNEE,
    ST_KN_LO,
    ST_KN_HI,
    ST_KN_SUM,
    ST_KN_Q,
    ST_FILT,
    ST_FILT_W,
    ST_WB
  } state_t;

  // clamp a widened signed value into the sample range
  function automatic logic signed [N-1:0] sat_fn(input logic signed [N+1:0] v);
    logic signed [N-1:0] r;
    if (v > SMAX_X) begin
      r = SMAX;
    end else if (v < SMIN_X) begin
      r = SMIN;
    end else begin
      r = signed'(v[N-1:0]);
    end
    return r;
  endfunction

  // magnitude of a sample; the most negative code maps to 2^(N-1)
  function automatic logic [N-1:0] abs_fn(input logic signed [N-1:0] v);
    logic [N-1:0] u;
    u = v;
    return u[N-1] ? (~u + 1'b1) : u;
  endfunction

  // configuration registers
  logic                pol_r;
  logic signed [N-1:0] thr_r;
  logic [N-2:0]        tw_r;
  logic [KNEE_SCALE_BITS-1:0] ks_r;
  logic [CF:0]         cc_r;
  logic [CF:0]         dc_r;
  logic                di_r;

  // control and held state
  state_t              state_r, state_nxt;
  logic signed [N-1:0] lvl_r, lvl_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic signed [N-1:0] out_level_r, out_level_nxt;
  logic                out_err_r, out_err_nxt;

  // working registers of the current word
  logic [N-1:0]        ar_r, ar_nxt;
  logic [N-1:0]        ai_r, ai_nxt;
  logic signed [N-1:0] s_r, s_nxt;
  logic signed [N-1:0] det_r, det_nxt;
  logic [D2W-1:0]      d2_r, d2_nxt;
  logic [PW-1:0]       acc_r, acc_nxt;
  logic                chg_r, chg_nxt;
  logic                err_r, err_nxt;

  // shared units
  logic                mul_en;
  logic [AW-1:0]       mul_a;
  logic [BW-1:0]       mul_b;
  logic [PRW-1:0]      prod_r;
  logic                sqrt_start;
  logic [2*N-1:0]      sqrt_rad;
  logic [N-1:0]        sqrt_root;
  logic                sqrt_done;

  // combinational helpers
  logic                cfg_bad;
  logic signed [N+1:0] s_x, thr_x, half_x, lo_edge, hi_edge, diff_st, kdist, ad;
  logic [N-2:0]        ad_u;
  logic signed [N-1:0] sm;
  logic                knee_ovf;
  logic [QW-1:0]       q;
  logic signed [N-1:0] kq;
  logic signed [N+1:0] det_x, lvl_x, cdiff, t_x;
  logic [CF:0]         c_clamp, k_clamp;
  logic [RW-1:0]       rnd;

  skpd_mul #(
    .AW (AW),
    .BW (BW)
  ) u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod_r)
  );

  skpd_sqrt #(
    .W (N)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (sqrt_rad),
    .root     (sqrt_root),
    .done     (sqrt_done)
  );

  assign in_ready         = (state_r == ST_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_level        = out_level_r;
  assign out_config_error = out_err_r;

  // Threshold sign against polarity: positive peaks want a threshold of zero
  // or above, negative peaks one of zero or below.
  assign cfg_bad = (!pol_r && thr_r[N-1]) || (pol_r && !thr_r[N-1] && (thr_r != '0));

  // sum of squares goes straight into the root unit
  assign sqrt_rad = acc_r[2*N-1:0] + prod_r[2*N-1:0];

  // Knee geometry. Edges are threshold -/+ half width; the distance is taken
  // from the lower edge for positive peaks and from the upper edge for
  // negative peaks, so its magnitude never exceeds the full width.
  always_comb begin
    s_x     = (N+2)'(s_r);
    thr_x   = (N+2)'(thr_r);
    half_x  = signed'((N+2)'(tw_r >> 1));
    lo_edge = thr_x - half_x;
    hi_edge = thr_x + half_x;
    diff_st = s_x - thr_x;
    kdist   = pol_r ? (s_x - hi_edge) : (s_x - lo_edge);
    ad      = pol_r ? -kdist : kdist;
    ad_u    = ad[N-2:0];
  end

  // Root to signed sample: clip to the largest code; the sequencer flips it for negative peaks.
  always_comb begin
    sm = (sqrt_root > SMAX_U) ? SMAX : signed'(sqrt_root);
  end

  // Knee curve: round half up at the Q2.15 point, clip at full scale; a
  // product past 64 bits counts as full scale.
  always_comb begin
    knee_ovf = ((acc_r >> 64) != '0);
    q        = QW'(acc_r >> KSH) + QW'(acc_r[KSH-1]);
    kq       = (knee_ovf || (q > QW'(SMAX_U))) ? SMAX : signed'(q[N-1:0]);
  end

  // Filter arithmetic: coefficients above 1.0 clip to 1.0, products round
  // half up at the coefficient point.
  always_comb begin
    det_x   = (N+2)'(det_r);
    lvl_x   = (N+2)'(lvl_r);
    cdiff   = det_x - lvl_x;
    c_clamp = (cc_r > COEF_ONE) ? COEF_ONE : cc_r;
    k_clamp = (dc_r > COEF_ONE) ? COEF_ONE : dc_r;
    rnd     = RW'(prod_r >> CF) + RW'(prod_r[CF-1]);
    t_x     = signed'((N+2)'(rnd[N-1:0]));
  end

  // Sequencer: one multiplier and the root unit are reused step by step.
  always_comb begin
    state_nxt     = state_r;
    lvl_nxt       = lvl_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_level_nxt = out_level_r;
    out_err_nxt   = out_err_r;
    ar_nxt        = ar_r;
    ai_nxt        = ai_r;
    s_nxt         = s_r;
    det_nxt       = det_r;
    d2_nxt        = d2_r;
    acc_nxt       = acc_r;
    chg_nxt       = chg_r;
    err_nxt       = err_r;
    mul_en        = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    sqrt_start    = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ar_nxt  = abs_fn(in_sample_re);
          ai_nxt  = abs_fn(in_sample_im);
          s_nxt   = in_sample_re;
          err_nxt = cfg_bad;
          priority if (cfg_bad) begin
            state_nxt = ST_WB;
          end else if (in_is_complex) begin
            state_nxt = ST_MAG_A;
          end else begin
            state_nxt = ST_KNEE;
          end
        end
      end

      ST_MAG_A: begin
        mul_en    = 1'b1;
        mul_a     = AW'(ar_r);
        mul_b     = BW'(ar_r);
        state_nxt = ST_MAG_B;
      end

      ST_MAG_B: begin
        acc_nxt   = PW'(prod_r);
        mul_en    = 1'b1;
        mul_a     = AW'(ai_r);
        mul_b     = BW'(ai_r);
        state_nxt = ST_MAG_C;
      end

      ST_MAG_C: begin
        sqrt_start = 1'b1;
        state_nxt  = ST_SQRT;
      end

      ST_SQRT: begin
        if (sqrt_done) begin
          s_nxt     = pol_r ? -sm : sm;
          state_nxt = ST_KNEE;
        end
      end

      ST_KNEE: begin
        if (!pol_r) begin
          priority if (tw_r == '0) begin
            det_nxt   = (s_x >= thr_x) ? sat_fn(diff_st) : '0;
            state_nxt = ST_FILT;
          end else if (s_x < lo_edge) begin
            det_nxt   = '0;
            state_nxt = ST_FILT;
          end else if (s_x > hi_edge) begin
            det_nxt   = sat_fn(diff_st);
            state_nxt = ST_FILT;
          end else begin
            mul_en    = 1'b1;
            mul_a     = AW'(ad_u);
            mul_b     = BW'(ad_u);
            state_nxt = ST_KN_LO;
          end
        end else begin
          priority if (tw_r == '0) begin
            det_nxt   = (s_x < thr_x) ? sat_fn(diff_st) : '0;
            state_nxt = ST_FILT;
          end else if (s_x > hi_edge) begin
            det_nxt   = '0;
            state_nxt = ST_FILT;
          end else if (s_x < lo_edge) begin
            det_nxt   = sat_fn(diff_st);
            state_nxt = ST_FILT;
          end else begin
            mul_en    = 1'b1;
            mul_a     = AW'(ad_u);
            mul_b     = BW'(ad_u);
            state_nxt = ST_KN_LO;
          end
        end
      end

      // squared distance times scale, in two halves of the square
      ST_KN_LO: begin
        d2_nxt    = prod_r[D2W-1:0];
        mul_en    = 1'b1;
        mul_a     = AW'(prod_r[H-1:0]);
        mul_b     = BW'(ks_r);
        state_nxt = ST_KN_HI;
      end

      ST_KN_HI: begin
        acc_nxt   = PW'(prod_r);
        mul_en    = 1'b1;
        mul_a     = AW'(d2_r[D2W-1:H]);
        mul_b     = BW'(ks_r);
        state_nxt = ST_KN_SUM;
      end

      ST_KN_SUM: begin
        acc_nxt   = acc_r + (PW'(prod_r) << H);
        state_nxt = ST_KN_Q;
      end

      ST_KN_Q: begin
        det_nxt   = pol_r ? -kq : kq;
        state_nxt = ST_FILT;
      end

      ST_FILT: begin
        priority if (det_r > lvl_r) begin
          mul_en    = 1'b1;
          mul_a     = AW'(cdiff[N-1:0]);
          mul_b     = BW'(c_clamp);
          chg_nxt   = 1'b1;
          state_nxt = ST_FILT_W;
        end else if (det_r < lvl_r) begin
          priority if (di_r) begin
            lvl_nxt   = det_r;
            state_nxt = ST_WB;
          end else if (!lvl_r[N-1] && (lvl_r != '0)) begin
            mul_en    = 1'b1;
            mul_a     = AW'(lvl_r[N-2:0]);
            mul_b     = BW'(k_clamp);
            chg_nxt   = 1'b0;
            state_nxt = ST_FILT_W;
          end else begin
            state_nxt = ST_WB;
          end
        end else begin
          state_nxt = ST_WB;
        end
      end

      ST_FILT_W: begin
        if (chg_r) begin
          if (rnd != '0) begin
            lvl_nxt = sat_fn(lvl_x + t_x);
          end
        end else if (t_x < lvl_x) begin
          lvl_nxt = signed'(t_x[N-1:0]);
        end
        state_nxt = ST_WB;
      end

      ST_WB: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_level_nxt = lvl_r;
          out_err_nxt   = err_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State, held level, result register and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lvl_r       <= '0;
      out_valid_r <= 1'b0;
      out_level_r <= '0;
      out_err_r   <= 1'b0;
      pol_r       <= 1'b0;
      thr_r       <= '0;
      tw_r        <= '0;
      ks_r        <= '0;
      cc_r        <= COEF_ONE;
      dc_r        <= DECAY_RST;
      di_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lvl_r       <= lvl_nxt;
      out_valid_r <= out_valid_nxt;
      out_level_r <= out_level_nxt;
      out_err_r   <= out_err_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_POLARITY:      pol_r <= cfg_data[0];
          REG_THRESHOLD:     thr_r <= signed'(cfg_data[N-1:0]);
          REG_TRANS_WIDTH:   tw_r  <= cfg_data[N-2:0];
          REG_KNEE_SCALE:    ks_r  <= cfg_data[KNEE_SCALE_BITS-1:0];
          REG_CHARGE_COEF:   cc_r  <= cfg_data[CF:0];
          REG_DECAY_COEF:    dc_r  <= cfg_data[CF:0];
          REG_DECAY_INSTANT: di_r  <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // Working registers of the word in flight.
  always_ff @(posedge clk) begin
    ar_r  <= ar_nxt;
    ai_r  <= ai_nxt;
    s_r   <= s_nxt;
    det_r <= det_nxt;
    d2_r  <= d2_nxt;
    acc_r <= acc_nxt;
    chg_r <= chg_nxt;
    err_r <= err_nxt;
  end

  // a root result only arrives while the sequencer waits for it
  a_sqrt_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sqrt_done |-> state_r == ST_SQRT)
    else $error("square root finished outside its wait state");

  // the charge path never lowers the level
  a_charge_up: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FILT_W && chg_r) |=> lvl_r >= $past(lvl_r))
    else $error("charge step lowered the held level");

  // the multiplicative decay never raises the level
  a_decay_down: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FILT_W && !chg_r) |=> lvl_r <= $past(lvl_r))
    else $error("decay step raised the held level");

  // a word with a threshold/polarity clash leaves the level alone
  a_err_holds_level: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WB && err_r) |-> $stable(lvl_r))
    else $error("held level moved on a configuration error word");

  // a fresh result is only loaded from the write-back step
  a_out_from_wb: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_WB)
    else $error("result appeared without a write-back step");

endmodule
